@@ rtl/core/hpr_pkg.sv @@
// Package for the horizontal polyphase resampler.
// Holds item kinds, field widths and the command record between front and back.
// No dependencies.
package hpr_pkg;

  localparam int unsigned SrcPixelsDef   = 4096;
  localparam int unsigned OutPixelsDef   = 4096;
  localparam int unsigned MaxTapsDef     = 16;
  localparam int unsigned MaxChannelsDef = 4;

  localparam int unsigned SampleW = 24;
  localparam int unsigned WeightW = 16;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_WEIGHT  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [11:0] out_pos;
    logic [11:0] start_pixel;
    logic [6:0]  taps;
    logic [2:0]  channels;
  } cmd_t;

endpackage

@@ rtl/core/horizontal_polyphase_resampler.sv @@
// Horizontal polyphase resampler, top level. Depends on hpr_pkg, hpr_front,
// hpr_back and hpr_out.
// Load items wait while any compute is queued or running.
// A compute item is worked in the back end one channel at a time, taps capped
// at MAX_TAPS; result stalls hold it.
// Reset clears control state and sets channel_count to 1; memories are not cleared.
module horizontal_polyphase_resampler #(
  parameter int unsigned SRC_PIXELS   = hpr_pkg::SrcPixelsDef,
  parameter int unsigned OUT_PIXELS   = hpr_pkg::OutPixelsDef,
  parameter int unsigned MAX_TAPS     = hpr_pkg::MaxTapsDef,
  parameter int unsigned MAX_CHANNELS = hpr_pkg::MaxChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind_i,
  input  logic [13:0]        sample_index_i,
  input  logic signed [23:0] sample_value_i,
  input  logic [11:0]        weight_output_i,
  input  logic [3:0]         weight_tap_i,
  input  logic signed [15:0] weight_value_i,
  input  logic [11:0]        out_pos_i,
  input  logic [11:0]        start_pixel_i,
  input  logic [4:0]         tap_count_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] channel_value_o,
  output logic [1:0]         channel_index_o,
  output logic               last_o
);
  import hpr_pkg::*;

  logic [2:0] chan_q;
  logic       s_we, w_we, cmd_v, cmd_take, back_busy;
  cmd_t       cmd;
  logic       r_v, r_take, r_last;
  logic signed [23:0] r_val;
  logic [1:0] r_ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chan_q <= 3'd1;
    else if (cfg_we_i) chan_q <= cfg_wdata_i;
  end

  hpr_front #(.OutPixels(OUT_PIXELS), .MaxTaps(MAX_TAPS), .MaxChannels(MAX_CHANNELS))
  u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .weight_output_i, .weight_tap_i,
    .out_pos_i, .start_pixel_i, .tap_count_i, .channel_count_i(chan_q),
    .back_busy_i(back_busy),
    .sample_we_o(s_we), .weight_we_o(w_we), .cmd_valid_o(cmd_v), .cmd_o(cmd),
    .cmd_take_i(cmd_take)
  );

  hpr_back #(.SrcPixels(SRC_PIXELS), .OutPixels(OUT_PIXELS), .MaxTaps(MAX_TAPS),
             .MaxChannels(MAX_CHANNELS))
  u_back (
    .clk_i, .rst_ni, .sample_we_i(s_we), .sample_index_i, .sample_value_i,
    .weight_we_i(w_we), .weight_output_i, .weight_tap_i, .weight_value_i,
    .cmd_valid_i(cmd_v), .cmd_i(cmd), .cmd_take_o(cmd_take), .busy_o(back_busy),
    .res_valid_o(r_v), .res_value_o(r_val), .res_channel_o(r_ch),
    .res_last_o(r_last), .res_take_i(r_take)
  );

  hpr_out u_out (
    .clk_i, .rst_ni, .in_valid_i(r_v), .in_value_i(r_val), .in_channel_i(r_ch),
    .in_last_i(r_last), .in_take_o(r_take), .empty, .pop,
    .value_o(channel_value_o), .channel_o(channel_index_o), .last_o
  );

endmodule

@@ rtl/core/hpr_front.sv @@
// Front end: accepts items, performs loads into the stores' write ports and
// queues compute commands. Depends on hpr_pkg.
module hpr_front #(
  parameter int unsigned OutPixels   = 4096,
  parameter int unsigned MaxTaps     = 16,
  parameter int unsigned MaxChannels = 4,
  parameter int unsigned QDepth      = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind_i,
  input  logic [11:0]         weight_output_i,
  input  logic [3:0]          weight_tap_i,
  input  logic [11:0]         out_pos_i,
  input  logic [11:0]         start_pixel_i,
  input  logic [4:0]          tap_count_i,
  input  logic [2:0]          channel_count_i,
  input  logic                back_busy_i,
  output logic                sample_we_o,
  output logic                weight_we_o,
  output logic                cmd_valid_o,
  output hpr_pkg::cmd_t       cmd_o,
  input  logic                cmd_take_i
);
  import hpr_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            acc, enq, deq;
  logic            is_load;
  cmd_t            cmd_new;
  logic [6:0]      taps_sat;
  logic [2:0]      ch_sat;

  // hold loads while any compute is queued or running
  assign is_load     = (kind_i == KIND_SAMPLE) || (kind_i == KIND_WEIGHT);
  assign full        = (cnt_q == (PtrW+1)'(QDepth))
                       || (is_load && ((cnt_q != '0) || back_busy_i));
  assign acc         = push && !full;
  assign sample_we_o = acc && (kind_i == KIND_SAMPLE);
  assign weight_we_o = acc && (kind_i == KIND_WEIGHT)
                       && (32'(weight_output_i) < OutPixels)
                       && (32'(weight_tap_i) < MaxTaps);
  assign enq         = acc && (kind_i == KIND_COMPUTE);
  assign cmd_valid_o = (cnt_q != '0);
  assign deq         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    if (32'(tap_count_i) > MaxTaps) taps_sat = 7'(MaxTaps);
    else taps_sat = 7'(tap_count_i);
    if (channel_count_i == 3'd0) ch_sat = 3'd1;
    else if (32'(channel_count_i) > MaxChannels) ch_sat = 3'(MaxChannels);
    else ch_sat = channel_count_i;
    cmd_new = '{out_pos: out_pos_i, start_pixel: start_pixel_i,
                taps: taps_sat, channels: ch_sat};
    wr_d  = enq ? ((32'(wr_q) == QDepth-1) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = deq ? ((32'(rd_q) == QDepth-1) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(enq) - (PtrW+1)'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_mem[wr_q] <= cmd_new;
  end

endmodule

@@ rtl/core/hpr_back.sv @@
// Back end: holds the sample and weight memories and walks the taps of one
// command per channel through a multiply-accumulate. Depends on hpr_pkg.
module hpr_back #(
  parameter int unsigned SrcPixels   = 4096,
  parameter int unsigned OutPixels   = 4096,
  parameter int unsigned MaxTaps     = 16,
  parameter int unsigned MaxChannels = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_we_i,
  input  logic [13:0]         sample_index_i,
  input  logic signed [23:0]  sample_value_i,
  input  logic                weight_we_i,
  input  logic [11:0]         weight_output_i,
  input  logic [3:0]          weight_tap_i,
  input  logic signed [15:0]  weight_value_i,
  input  logic                cmd_valid_i,
  input  hpr_pkg::cmd_t       cmd_i,
  output logic                cmd_take_o,
  output logic                busy_o,
  output logic                res_valid_o,
  output logic signed [23:0]  res_value_o,
  output logic [1:0]          res_channel_o,
  output logic                res_last_o,
  input  logic                res_take_i
);
  import hpr_pkg::*;

  localparam int unsigned SrcDepth = SrcPixels * MaxChannels;
  localparam int unsigned WtDepth  = OutPixels * MaxTaps;
  localparam int unsigned SaW      = $clog2(SrcDepth);
  localparam int unsigned WaW      = $clog2(WtDepth);
  localparam int unsigned AccW     = 48;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic signed [23:0] src_mem [SrcDepth];
  logic signed [15:0] wt_mem  [WtDepth];

  logic [2:0]  st_q, st_d;
  cmd_t        cmd_q;
  logic [1:0]  ch_q;
  logic [6:0]  tap_q;
  logic [31:0] sa_full;
  logic [31:0] wa_full;
  logic        rd_ok_q, rd_go_q, rd_go_d;
  logic        wt_ok_q;
  logic signed [23:0] s_rd_q;
  logic signed [15:0] w_rd_q;
  logic signed [39:0] prod_q;
  logic        prod_v_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] rnd;
  logic signed [23:0] sat;
  logic        issue;

  assign sa_full = (32'(cmd_q.start_pixel) + 32'(tap_q)) * 32'(cmd_q.channels) + 32'(ch_q);
  assign wa_full = 32'(cmd_q.out_pos) * MaxTaps + 32'(tap_q);
  assign issue   = (st_q == StRun) && (tap_q < cmd_q.taps);

  always_ff @(posedge clk_i) begin
    if (sample_we_i && (32'(sample_index_i) < SrcDepth))
      src_mem[SaW'(sample_index_i)] <= sample_value_i;
    if (weight_we_i)
      wt_mem[WaW'(32'(weight_output_i) * MaxTaps + 32'(weight_tap_i))] <= weight_value_i;
    s_rd_q  <= src_mem[SaW'(sa_full)];
    w_rd_q  <= wt_mem[WaW'(wa_full)];
    rd_ok_q <= sa_full < SrcDepth;
    wt_ok_q <= 32'(cmd_q.out_pos) < OutPixels;
    prod_q  <= (rd_ok_q && wt_ok_q) ? 40'(s_rd_q) * 40'(w_rd_q) : '0;
    if (st_q == StIdle && cmd_valid_i) cmd_q <= cmd_i;
  end

  always_comb begin
    rnd = (acc_q + AccW'(8192)) >>> 14;
    if (rnd > AccW'(8388607)) sat = 24'sh7FFFFF;
    else if (rnd < -AccW'(8388608)) sat = -24'sh800000;
    else sat = rnd[23:0];
    rd_go_d = issue;
  end

  assign cmd_take_o    = (st_q == StIdle) && cmd_valid_i;
  assign busy_o        = (st_q != StIdle);
  assign res_valid_o   = (st_q == StOut);
  assign res_value_o   = sat;
  assign res_channel_o = ch_q;
  assign res_last_o    = (3'(ch_q) + 3'd1 == cmd_q.channels);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (cmd_valid_i) st_d = StRun;
      StRun:   if (!issue) st_d = StDrain;
      StDrain: if (!rd_go_q && !prod_v_q) st_d = StOut;
      StOut:   if (res_take_i) st_d = res_last_o ? StIdle : StRun;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ch_q     <= '0;
      tap_q    <= '0;
      rd_go_q  <= 1'b0;
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      st_q     <= st_d;
      rd_go_q  <= rd_go_d;
      prod_v_q <= rd_go_q;
      if (issue) tap_q <= tap_q + 7'd1;
      if (prod_v_q) acc_q <= acc_q + AccW'(prod_q);
      if (st_q == StIdle) begin
        ch_q  <= '0;
        tap_q <= '0;
        acc_q <= '0;
      end else if (st_q == StOut && res_take_i) begin
        ch_q  <= ch_q + 2'd1;
        tap_q <= '0;
        acc_q <= '0;
      end
    end
  end

endmodule

@@ rtl/core/hpr_out.sv @@
// Output queue: two-entry result buffer presented as a queue with empty/pop.
// Depends on hpr_pkg.
module hpr_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic signed [23:0] in_value_i,
  input  logic [1:0]         in_channel_i,
  input  logic               in_last_i,
  output logic               in_take_o,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] value_o,
  output logic [1:0]         channel_o,
  output logic               last_o
);
  import hpr_pkg::*;

  logic [26:0] buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        enq, deq;

  assign in_take_o = in_valid_i && (cnt_q != 2'd2);
  assign enq       = in_take_o;
  assign empty     = (cnt_q == 2'd0);
  assign deq       = pop && !empty;
  assign {value_o, channel_o, last_o} = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (enq) buf_q[wr_q] <= {in_value_i, in_channel_i, in_last_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (enq) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(enq) - 2'(deq);
    end
  end

endmodule

@@ tb/hpr_checker.sv @@
// Checker for the horizontal polyphase resampler: watches the item, result and
// register ports, predicts each channel value and compares in order.
// Depends on hpr_pkg.
`timescale 1ns / 100ps
module hpr_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [1:0]         kind_i,
  input  logic [13:0]        sample_index_i,
  input  logic signed [23:0] sample_value_i,
  input  logic [11:0]        weight_output_i,
  input  logic [3:0]         weight_tap_i,
  input  logic signed [15:0] weight_value_i,
  input  logic [11:0]        out_pos_i,
  input  logic [11:0]        start_pixel_i,
  input  logic [4:0]         tap_count_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [23:0] channel_value_i,
  input  logic [1:0]         channel_index_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o
);
  import hpr_pkg::*;

  typedef struct {
    logic signed [23:0] value;
    logic [1:0]         chan;
    logic               last;
  } pixel_result_t;

  logic signed [23:0] row_mem [16384];
  logic signed [15:0] tap_mem [65536];
  logic [2:0]         chan_reg;
  pixel_result_t      pixel_q [$];

  assign pending_o = pixel_q.size();

  task automatic predict_pixel(input logic [11:0] pos, input logic [11:0] start,
                               input logic [4:0] taps_in);
    int            nch;
    int            ntap;
    int            addr;
    longint        acc;
    longint        q;
    pixel_result_t r;
    begin
      nch = (chan_reg == 0) ? 1 : (chan_reg > 4) ? 4 : chan_reg;
      ntap = (taps_in > 16) ? 16 : taps_in;
      for (int c = 0; c < nch; c++) begin
        acc = 0;
        for (int t = 0; t < ntap; t++) begin
          addr = (int'(start) + t) * nch + c;
          if (addr < 16384)
            acc += longint'(tap_mem[int'(pos) * 16 + t]) * longint'(row_mem[addr]);
        end
        q = (acc + 64'sd8192) >>> 14;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        r.value = q[23:0];
        r.chan = c[1:0];
        r.last = (c + 1 == nch);
        pixel_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_reg <= 3'd1;
      pixel_q.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) chan_reg <= cfg_wdata_i;
      if (push_i && !full_i) begin
        case (kind_e'(kind_i))
          KIND_SAMPLE: row_mem[sample_index_i] = sample_value_i;
          KIND_WEIGHT: tap_mem[{weight_output_i, weight_tap_i}] = weight_value_i;
          KIND_COMPUTE: predict_pixel(out_pos_i, start_pixel_i, tap_count_i);
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        results_o <= results_o + 1;
        if (pixel_q.size() == 0) begin
          $error("result with nothing expected: value %0d channel %0d",
                 channel_value_i, channel_index_i);
          errors_o <= errors_o + 1;
        end else begin
          pixel_result_t e;
          e = pixel_q.pop_front();
          if (e.value !== channel_value_i || e.chan !== channel_index_i ||
              e.last !== last_i) begin
            errors_o <= errors_o + 1;
            if (e.value !== channel_value_i)
              $error("channel_value: expected %0d, got %0d", e.value, channel_value_i);
            if (e.chan !== channel_index_i)
              $error("channel_index: expected %0d, got %0d", e.chan, channel_index_i);
            if (e.last !== last_i)
              $error("last: expected %0b, got %0b", e.last, last_i);
          end
        end
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
// Top of the resampler testbench: clock, reset, item and register stimulus,
// result stall pattern, watchdog and verdict. Depends on hpr_pkg,
// horizontal_polyphase_resampler and hpr_checker.
`timescale 1ns / 100ps
module testbench;
  import hpr_pkg::*;

  localparam int IdleLimit = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         kind_r = KIND_NONE;
  logic [13:0]        sample_index_r = '0;
  logic signed [23:0] sample_value_r = '0;
  logic [11:0]        weight_output_r = '0;
  logic [3:0]         weight_tap_r = '0;
  logic signed [15:0] weight_value_r = '0;
  logic [11:0]        out_pos_r = '0;
  logic [11:0]        start_pixel_r = '0;
  logic [4:0]         tap_count_r = '0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_wdata = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [23:0] channel_value;
  logic [1:0]         channel_index;
  logic               last;
  int                 errors;
  int                 pending;
  int                 results;

  bit       row_seen [16384];
  bit       tap_seen [65536];
  logic [2:0] chan_cfg = 3'd1;
  int       burst_left = 1;
  int       n_items = 0;
  int       n_compute = 0;
  int       idle_cycles = 0;
  int       pop_cycle = 0;

  horizontal_polyphase_resampler u_dut (
    .clk_i, .rst_ni, .push, .full,
    .kind_i(kind_r), .sample_index_i(sample_index_r), .sample_value_i(sample_value_r),
    .weight_output_i(weight_output_r), .weight_tap_i(weight_tap_r),
    .weight_value_i(weight_value_r), .out_pos_i(out_pos_r),
    .start_pixel_i(start_pixel_r), .tap_count_i(tap_count_r),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .empty, .pop,
    .channel_value_o(channel_value), .channel_index_o(channel_index), .last_o(last)
  );

  hpr_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .kind_i(kind_r),
    .sample_index_i(sample_index_r), .sample_value_i(sample_value_r),
    .weight_output_i(weight_output_r), .weight_tap_i(weight_tap_r),
    .weight_value_i(weight_value_r), .out_pos_i(out_pos_r),
    .start_pixel_i(start_pixel_r), .tap_count_i(tap_count_r),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .empty_i(empty), .pop_i(pop),
    .channel_value_i(channel_value), .channel_index_i(channel_index), .last_i(last),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // stall pattern: free flow, light stalls, heavy stalls, fixed duty
  always @(negedge clk_i) begin
    pop_cycle <= pop_cycle + 1;
    case ((pop_cycle / 150) % 4)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= ((pop_cycle % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'($urandom_range(0, 65535)) - 24'sd32768;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic stage_noise();
    begin
      sample_index_r = 14'($urandom);
      sample_value_r = 24'($urandom);
      weight_output_r = 12'($urandom);
      weight_tap_r = 4'($urandom);
      weight_value_r = 16'($urandom);
      out_pos_r = 12'($urandom);
      start_pixel_r = 12'($urandom);
      tap_count_r = 5'($urandom);
    end
  endtask

  task automatic hold_sender();
    begin
      @(negedge clk_i);
      push = 1'b0;
    end
  endtask

  // present one item and hold it until accepted, then maybe end the burst
  task automatic send(input kind_e k, input logic [13:0] si, input logic signed [23:0] sv,
                      input logic [11:0] wo, input logic [3:0] wt,
                      input logic signed [15:0] wv, input logic [11:0] op,
                      input logic [11:0] sp, input logic [4:0] tc);
    begin
      @(negedge clk_i);
      stage_noise();
      kind_r = k;
      case (k)
        KIND_SAMPLE: begin
          sample_index_r = si;
          sample_value_r = sv;
        end
        KIND_WEIGHT: begin
          weight_output_r = wo;
          weight_tap_r = wt;
          weight_value_r = wv;
        end
        KIND_COMPUTE: begin
          out_pos_r = op;
          start_pixel_r = sp;
          tap_count_r = tc;
        end
        default: ;
      endcase
      push = 1'b1;
      @(posedge clk_i);
      while (full) @(posedge clk_i);
      if (k == KIND_SAMPLE) row_seen[si] = 1'b1;
      if (k == KIND_WEIGHT) tap_seen[{wo, wt}] = 1'b1;
      if (k == KIND_COMPUTE) n_compute++;
      if (k != KIND_NONE) n_items++;
      burst_left--;
      if (burst_left <= 0) begin
        @(negedge clk_i);
        push = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
    end
  endtask

  task automatic put_sample(input logic [13:0] si, input logic signed [23:0] sv);
    send(KIND_SAMPLE, si, sv, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic put_weight(input logic [11:0] wo, input logic [3:0] wt,
                            input logic signed [15:0] wv);
    send(KIND_WEIGHT, '0, '0, wo, wt, wv, '0, '0, '0);
  endtask

  // load whatever the pixel will read that was never loaded, then compute it
  task automatic resample(input logic [11:0] op, input logic [11:0] sp, input logic [4:0] tc);
    int nch;
    int ntap;
    int addr;
    begin
      nch = (chan_cfg == 0) ? 1 : (chan_cfg > 4) ? 4 : chan_cfg;
      ntap = (tc > 16) ? 16 : tc;
      for (int t = 0; t < ntap; t++) begin
        if (!tap_seen[{op, 4'(t)}]) put_weight(op, 4'(t), rand_weight());
        for (int c = 0; c < nch; c++) begin
          addr = (int'(sp) + t) * nch + c;
          if (addr < 16384 && !row_seen[addr]) put_sample(14'(addr), rand_sample());
        end
      end
      send(KIND_COMPUTE, '0, '0, '0, '0, '0, op, sp, tc);
    end
  endtask

  task automatic drain();
    begin
      hold_sender();
      wait (pending == 0);
      repeat (40) @(posedge clk_i);
    end
  endtask

  task automatic set_channels(input logic [2:0] v);
    begin
      drain();
      @(negedge clk_i);
      cfg_we = 1'b1;
      cfg_wdata = v;
      chan_cfg = v;
      @(negedge clk_i);
      cfg_we = 1'b0;
    end
  endtask

  initial begin
    logic [2:0] phase_cfg [6];
    int         goal;
    phase_cfg = '{3'd2, 3'd4, 3'd3, 3'd1, 3'd7, 3'd2};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // rounding ties, full-scale products, zero and oversized tap counts
    put_sample(14'd0, 24'sd1);
    put_sample(14'd1, -24'sd1);
    put_weight(12'd0, 4'd0, 16'sd8192);
    resample(12'd0, 12'd0, 5'd1);
    resample(12'd0, 12'd1, 5'd1);
    resample(12'd0, 12'd0, 5'd0);
    put_sample(14'd2, 24'sh7FFFFF);
    put_weight(12'd1, 4'd0, -16'sh8000);
    resample(12'd1, 12'd2, 5'd1);
    send(KIND_NONE, 14'h3FFF, -24'sd1, 12'hFFF, 4'hF, -16'sd1, 12'hFFF, 12'hFFF, 5'h1F);
    resample(12'd4095, 12'd4095, 5'd31);
    set_channels(3'd0);
    resample(12'd4095, 12'd3, 5'd16);
    set_channels(3'd4);
    resample(12'd4095, 12'd4095, 5'd2);
    resample(12'd4095, 12'd4091, 5'd17);
    set_channels(3'd5);
    resample(12'd4095, 12'd0, 5'd3);

    // random phases, one channel setting each
    foreach (phase_cfg[p]) begin
      set_channels(phase_cfg[p]);
      goal = n_items + 4;
      while (n_items < goal) begin
        case ($urandom_range(0, 19))
          0, 1, 2: put_sample(14'($urandom), rand_sample());
          3, 4: put_weight(12'($urandom), 4'($urandom), rand_weight());
          5: send(KIND_NONE, '0, '0, '0, '0, '0, '0, '0, '0);
          6: resample(12'($urandom), 12'($urandom), 5'($urandom_range(0, 31)));
          default: resample(12'($urandom_range(0, 15)), 12'($urandom_range(0, 31)),
                            5'($urandom_range(0, 6)));
        endcase
        if (p == 2 && n_items == goal - 2) drain();
      end
    end

    drain();
    $display("covered %0d items (%0d pixel computes) giving %0d channel results,",
             n_items, n_compute, results);
    $display("channel settings 0 to 7 including out-of-range ones and tap counts 0 to 31");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
